// ----- hdl/uart_baud_divisor_and_line_control_core_assert.svh -----
// Assertion macros shared by the line-setting core.
`ifndef UART_BAUD_DIVISOR_AND_LINE_CONTROL_CORE_ASSERT_SVH
`define UART_BAUD_DIVISOR_AND_LINE_CONTROL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UBDLC_ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("ubdlc assertion failed");

// Next-cycle implication, checked out of reset.
`define UBDLC_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("ubdlc assertion failed");

`endif

// ----- hdl/ubdlc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ubdlc_pkg;

    localparam int unsigned BAUD_W  = 24;
    localparam int unsigned CLK_W   = 31;
    localparam int unsigned TOL_W   = 10;
    localparam int unsigned LCR_W   = 8;
    localparam int unsigned DIV_W   = 16;

    localparam logic [CLK_W-1:0] CLOCK_RESET = 31'd1843200;
    localparam logic [TOL_W-1:0] TOL_RESET   = 10'd30;
    localparam logic [10:0]      ERR_SCALE   = 11'd2000;

    localparam logic REG_CLOCK = 1'b0;
    localparam logic REG_TOL   = 1'b1;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic [3:0]        data_bits;
        logic [1:0]        stop_bits;
        logic [2:0]        parity_code;
    } t_req;

    typedef struct packed {
        logic [LCR_W-1:0] line_control;
        logic [DIV_W-1:0] divisor_value;
        logic             load_divisor;
        logic             status;
    } t_result;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [LCR_W-1:0]  lcr;
    } t_job;

endpackage
`default_nettype wire

// ----- hdl/uart_baud_divisor_and_line_control_core.sv -----
// UART line-setting core for a 16550-style port with 16x oversampling.
// A request is presented on i_req with start high; it is taken at a rising
// edge where start is high and busy is low. The core returns one result per
// request on o_result, marked by o_done for exactly one cycle.
// The result carries the line control byte, the 16-bit divisor, a load flag
// and a status bit that is set when the baud rate cannot be met.
// The reference clock and the tolerance are set over the APB port at byte
// addresses 0 and 4; the user must change them only while no request is
// in flight, and the core does not enforce this. A front stage classifies
// each request and builds the line control byte, a two-entry queue passes
// it on, and the back end runs three pipelined restoring dividers of one
// quotient bit per stage. A request passes the front register, the queue
// entry, 31 + 31 + 43 divider stages and four pipeline registers.
// A new request is taken every cycle, so busy stays low in use.
// Reset clears all valid flags and loads the register reset values.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_baud_divisor_and_line_control_core_assert.svh"
module uart_baud_divisor_and_line_control_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ubdlc_pkg::t_req     i_req,
    output logic                     o_done,
    output ubdlc_pkg::t_result       o_result,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import ubdlc_pkg::*;

    logic [CLK_W-1:0] r_clock_hz;
    logic [TOL_W-1:0] r_tol;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_RESET;
            r_tol      <= TOL_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_CLOCK) begin
                r_clock_hz <= pwdata[CLK_W-1:0];
            end else begin
                r_tol <= pwdata[TOL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_TOL) ? {{(32-TOL_W){1'b0}}, r_tol}
                                          : {{(32-CLK_W){1'b0}}, r_clock_hz};

    logic fifo_ready;
    logic fifo_valid;
    logic push;
    t_job front_job;
    t_job head_job;

    ubdlc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_fifo_ready (fifo_ready),
        .o_busy       (busy),
        .o_push       (push),
        .o_job        (front_job)
    );

    ubdlc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_ready (fifo_ready),
        .o_valid (fifo_valid),
        .o_job   (head_job)
    );

    ubdlc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (fifo_valid),
        .i_job      (head_job),
        .i_clock_hz (r_clock_hz),
        .i_tol      (r_tol),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    `UBDLC_ASSERT_SAME(a_load_ok, o_done && o_result.load_divisor, !o_result.status && (o_result.divisor_value != 16'd0))
    `UBDLC_ASSERT_SAME(a_reject_clean, o_done && o_result.status, !o_result.load_divisor && (o_result.line_control == 8'd0) && (o_result.divisor_value == 16'd0))
    `UBDLC_ASSERT_NEXT(a_queue_drains, !fifo_ready, fifo_ready)

endmodule
`default_nettype wire

// ----- hdl/ubdlc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubdlc_div #(
    parameter int unsigned NW = 31,
    parameter int unsigned DW = 27,
    parameter int unsigned SW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo,
    output logic [SW-1:0]      o_side
);

    logic [DW-1:0] r_rem  [1:NW];
    logic [NW-1:0] r_num  [1:NW];
    logic [NW-1:0] r_quo  [1:NW];
    logic [DW-1:0] r_den  [1:NW];
    logic [SW-1:0] r_side [1:NW];
    logic          r_vld  [1:NW];

    logic [DW-1:0] c_rem  [0:NW-1];
    logic [NW-1:0] c_num  [0:NW-1];
    logic [NW-1:0] c_quo  [0:NW-1];
    logic [DW-1:0] c_den  [0:NW-1];
    logic [SW-1:0] c_side [0:NW-1];
    logic          c_vld  [0:NW-1];

    logic [DW-1:0] n_rem  [0:NW-1];
    logic [NW-1:0] n_quo  [0:NW-1];

    always_comb begin
        for (int k = 0; k < NW; k++) begin
            if (k == 0) begin
                c_rem[k]  = '0;
                c_num[k]  = i_num;
                c_quo[k]  = '0;
                c_den[k]  = i_den;
                c_side[k] = i_side;
                c_vld[k]  = i_valid;
            end else begin
                c_rem[k]  = r_rem[k];
                c_num[k]  = r_num[k];
                c_quo[k]  = r_quo[k];
                c_den[k]  = r_den[k];
                c_side[k] = r_side[k];
                c_vld[k]  = r_vld[k];
            end
        end
    end

    always_comb begin
        logic [DW:0] t;
        logic [DW:0] sub;
        logic        ge;
        for (int k = 0; k < NW; k++) begin
            t   = {c_rem[k], c_num[k][NW-1]};
            sub = t - {1'b0, c_den[k]};
            ge  = (t >= {1'b0, c_den[k]});
            n_rem[k] = ge ? sub[DW-1:0] : t[DW-1:0];
            n_quo[k] = {c_quo[k][NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NW; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_num[k+1]  <= {c_num[k][NW-2:0], 1'b0};
            r_quo[k+1]  <= n_quo[k];
            r_den[k+1]  <= c_den[k];
            r_side[k+1] <= c_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < NW; k++) begin
                r_vld[k+1] <= c_vld[k];
            end
        end
    end

    assign o_valid = r_vld[NW];
    assign o_quo   = r_quo[NW];
    assign o_side  = r_side[NW];

endmodule
`default_nettype wire

// ----- hdl/ubdlc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubdlc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ubdlc_pkg::t_req i_req,
    input  wire logic          i_fifo_ready,
    output logic               o_busy,
    output logic               o_push,
    output ubdlc_pkg::t_job    o_job
);
    import ubdlc_pkg::*;

    logic r_vld;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_busy = r_vld && !i_fifo_ready;
    assign accept = i_start && !o_busy;

    always_comb begin
        n_job.baud = i_req.baud_rate;
        n_job.lcr  = '0;
        if (i_req.data_bits >= 4'd8) begin
            n_job.lcr[1:0] = 2'd3;
        end else if (i_req.data_bits == 4'd7) begin
            n_job.lcr[1:0] = 2'd2;
        end else if (i_req.data_bits == 4'd6) begin
            n_job.lcr[1:0] = 2'd1;
        end else begin
            n_job.lcr[1:0] = 2'd0;
        end
        n_job.lcr[2]   = (i_req.stop_bits > 2'd1);
        n_job.lcr[5:3] = i_req.parity_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_fifo_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

    assign o_push = r_vld && i_fifo_ready;
    assign o_job  = r_job;

endmodule
`default_nettype wire

// ----- hdl/ubdlc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubdlc_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ubdlc_pkg::t_job i_job,
    output logic                 o_ready,
    output logic                 o_valid,
    output ubdlc_pkg::t_job      o_job
);
    import ubdlc_pkg::*;

    t_job       r_mem [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_push && o_ready;
    assign pop     = o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ----- hdl/ubdlc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubdlc_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire ubdlc_pkg::t_job          i_job,
    input  wire logic [ubdlc_pkg::CLK_W-1:0] i_clock_hz,
    input  wire logic [ubdlc_pkg::TOL_W-1:0] i_tol,
    output logic                          o_done,
    output ubdlc_pkg::t_result            o_result
);
    import ubdlc_pkg::*;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [LCR_W-1:0]  lcr;
        logic              zero;
    } t_side1;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [LCR_W-1:0]  lcr;
        logic              zero;
        logic              rej;
        logic [DIV_W-1:0]  div;
    } t_side2;

    typedef struct packed {
        logic [LCR_W-1:0] lcr;
        logic             zero;
        logic             rej;
        logic [DIV_W-1:0] div;
        logic             neg;
    } t_side3;

    // First divide: clock / (8 * baud), then rounded halving.
    t_side1            s1_in;
    t_side1            s1_out;
    logic              d1_vld;
    logic [CLK_W-1:0]  d1_quo;

    assign s1_in.baud = i_job.baud;
    assign s1_in.lcr  = i_job.lcr;
    assign s1_in.zero = (i_job.baud == '0);

    ubdlc_div #(.NW(CLK_W), .DW(BAUD_W + 3), .SW($bits(t_side1))) u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   (i_clock_hz),
        .i_den   ({i_job.baud, 3'b000}),
        .i_side  (s1_in),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (s1_out)
    );

    logic         r2_vld;
    t_side2       r2_side;
    t_side2       n2_side;
    logic [CLK_W:0] sum1;
    logic [CLK_W-1:0] divf;

    always_comb begin
        sum1          = {1'b0, d1_quo} + {{CLK_W{1'b0}}, 1'b1};
        divf          = sum1[CLK_W:1];
        n2_side.baud  = s1_out.baud;
        n2_side.lcr   = s1_out.lcr;
        n2_side.zero  = s1_out.zero;
        n2_side.rej   = (divf == '0) || (divf[CLK_W-1:DIV_W] != '0);
        n2_side.div   = divf[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r2_side <= n2_side;
    end

    // Second divide: achieved baud = clock / (16 * divisor).
    t_side2           s2_out;
    logic             d2_vld;
    logic [CLK_W-1:0] d2_quo;

    ubdlc_div #(.NW(CLK_W), .DW(DIV_W + 4), .SW($bits(t_side2))) u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (i_clock_hz),
        .i_den   ({r2_side.div, 4'b0000}),
        .i_side  (r2_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (s2_out)
    );

    logic               r3_vld;
    logic [CLK_W:0]     r3_mag;
    logic [BAUD_W-1:0]  r3_baud;
    t_side3             r3_side;
    logic signed [CLK_W+1:0] diff;

    always_comb begin
        diff = $signed({2'b00, d2_quo}) - $signed({{(CLK_W+2-BAUD_W){1'b0}}, s2_out.baud});
    end

    always_ff @(posedge i_clk) begin
        r3_mag       <= diff[CLK_W+1] ? {(CLK_W+1){1'b0}} - diff[CLK_W:0] : diff[CLK_W:0];
        r3_baud      <= s2_out.baud;
        r3_side.lcr  <= s2_out.lcr;
        r3_side.zero <= s2_out.zero;
        r3_side.rej  <= s2_out.rej;
        r3_side.div  <= s2_out.div;
        r3_side.neg  <= diff[CLK_W+1];
    end

    localparam int unsigned PW = CLK_W + 1 + 11;

    logic              r4_vld;
    logic [PW-1:0]     r4_prod;
    logic [BAUD_W-1:0] r4_baud;
    t_side3            r4_side;

    always_ff @(posedge i_clk) begin
        r4_prod <= {11'b0, r3_mag} * {{(PW-11){1'b0}}, ERR_SCALE};
        r4_baud <= r3_baud;
        r4_side <= r3_side;
    end

    // Third divide: error magnitude * 2000 / baud.
    t_side3         s3_out;
    logic           d3_vld;
    logic [PW-1:0]  d3_quo;

    ubdlc_div #(.NW(PW), .DW(BAUD_W), .SW($bits(t_side3))) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .i_num   (r4_prod),
        .i_den   (r4_baud),
        .i_side  (r4_side),
        .o_valid (d3_vld),
        .o_quo   (d3_quo),
        .o_side  (s3_out)
    );

    logic signed [PW+1:0] err_e;
    logic signed [PW+1:0] err_h;
    logic signed [PW+1:0] tol_s;
    logic                 out_tol;
    t_result              n_result;
    t_result              r_result;
    logic                 r_done;

    always_comb begin
        err_e   = s3_out.neg ? -$signed({2'b00, d3_quo}) : $signed({2'b00, d3_quo});
        err_h   = (err_e + $signed({{(PW+1){1'b0}}, 1'b1})) >>> 1;
        tol_s   = $signed({{(PW+2-TOL_W){1'b0}}, i_tol});
        out_tol = (err_h > tol_s) || (err_h < -tol_s);
        if (s3_out.zero) begin
            n_result.line_control  = s3_out.lcr;
            n_result.divisor_value = '0;
            n_result.load_divisor  = 1'b0;
            n_result.status        = 1'b0;
        end else if (s3_out.rej || out_tol) begin
            n_result.line_control  = '0;
            n_result.divisor_value = '0;
            n_result.load_divisor  = 1'b0;
            n_result.status        = 1'b1;
        end else begin
            n_result.line_control  = s3_out.lcr;
            n_result.divisor_value = s3_out.div;
            n_result.load_divisor  = 1'b1;
            n_result.status        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r2_vld <= d1_vld;
            r3_vld <= d2_vld;
            r4_vld <= r3_vld;
            r_done <= d3_vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire
